[hw/rtl/assert_macros.svh]
// assertion macros included by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define THLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define THLP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/thlp_pkg.sv]
// shared types and constants for the timed level history peak block
package thlp_pkg;

    typedef logic signed [31:0] word_t;

    // level and stamp packed together in one history entry
    typedef struct packed {
        word_t stamp;
        word_t level;
    } entry_t;

    // status out of the shared compare unit
    typedef struct packed {
        word_t peak;
        logic  later;
    } scan_result_t;

    localparam word_t PEAK_INIT = -32'sd1;

endpackage

[hw/rtl/thlp_ram.sv]
// generic single write port, single read port ram with registered read
module thlp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/thlp_scan.sv]
// shared compare unit: running maximum and later-than test for one entry
module thlp_scan (
    input  thlp_pkg::entry_t       entry,
    input  thlp_pkg::word_t        query,
    input  thlp_pkg::word_t        peak,
    output thlp_pkg::scan_result_t result
);

    logic [31:0] diff;

    // wrapping difference read as signed
    assign diff = entry.stamp - query;

    always_comb
    begin
        result.peak  = (entry.level > peak) ? entry.level : peak;
        result.later = !diff[31] && (diff != 32'd0);
    end

endmodule

[hw/rtl/timed_level_history_peak_core.sv]
// top level of the timed level history peak block
//
// channel  | direction | handshake              | fields
// ---------+-----------+------------------------+---------------------------
// request  | in        | start && !busy         | command, time_stamp, level
// result   | out       | result_valid (1 cycle) | peak_level, last_time
//
// a record request is written to the ring at the accepting edge; busy stays
// low, so records can follow each other every cycle while no lookup runs
// a lookup does a ram read, then a compare, per entry (ST_ISSUE, ST_EVAL),
// from one to HIST_DEPTH entries, set by the single read port and the shared
// compare unit; the result strobe follows the last compare with busy low
// reset clears pointers and the fill flag; never-written entries read as zero
// through the fill flag and write pointer, so no clearing pass is needed
// the receiver cannot stall: the result is shown for exactly one cycle
`include "assert_macros.svh"

module timed_level_history_peak_core #(
    parameter int HIST_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic signed [31:0]  time_stamp,
    input  logic signed [31:0]  level,
    output logic                result_valid,
    output logic signed [31:0]  peak_level,
    output logic signed [31:0]  last_time
);

    localparam int AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(HIST_DEPTH - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic              full_reg, full_next;
    logic [AW-1:0]     scan_start_reg, scan_start_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     count_reg, count_next;
    thlp_pkg::word_t   query_reg, query_next;
    thlp_pkg::word_t   peak_reg, peak_next;
    logic              valid_reg, valid_next;
    thlp_pkg::word_t   last_reg, last_next;

    logic              accept;
    logic              rec_en;
    thlp_pkg::entry_t  wr_entry;
    logic [63:0]       rd_data;
    thlp_pkg::entry_t  entry;
    logic              entry_written;
    thlp_pkg::scan_result_t scan;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign rec_en = accept && !command;

    assign wr_entry.stamp = time_stamp;
    assign wr_entry.level = level;

    // one entry per ring slot, stamp and level side by side
    thlp_ram #(
        .WIDTH (64),
        .DEPTH (HIST_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (rec_en),
        .wr_addr (wp_reg),
        .wr_data (wr_entry),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // slots never written since reset read as zero stamp and zero level
    assign entry_written = full_reg || (idx_reg < wp_reg);
    assign entry         = entry_written ? thlp_pkg::entry_t'(rd_data) : '0;

    thlp_scan u_scan (
        .entry  (entry),
        .query  (query_reg),
        .peak   (peak_reg),
        .result (scan)
    );

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        full_next       = full_reg;
        scan_start_next = scan_start_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        query_next      = query_reg;
        peak_next       = peak_reg;
        valid_next      = 1'b0;
        last_next       = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !command)
                begin
                    // record: advance the write pointer with wrap
                    if (wp_reg == LAST_IDX)
                    begin
                        wp_next   = '0;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        wp_next = wp_reg + 1'b1;
                    end
                end
                else if (accept)
                begin
                    // lookup: start walking from the remembered position
                    idx_next   = scan_start_reg;
                    count_next = '0;
                    query_next = time_stamp;
                    peak_next  = thlp_pkg::PEAK_INIT;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                // ram read of idx_reg is in flight
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                peak_next = scan.peak;
                last_next = entry.stamp;
                if (scan.later)
                begin
                    // later entry found: it becomes the next start
                    scan_start_next = idx_reg;
                    valid_next      = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (count_reg == LAST_IDX)
                begin
                    // full circle without a later entry, start kept
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            full_reg       <= 1'b0;
            scan_start_reg <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            full_reg       <= full_next;
            scan_start_reg <= scan_start_next;
            valid_reg      <= valid_next;
        end
    end

    // payload and walk registers, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        count_reg <= count_next;
        query_reg <= query_next;
        peak_reg  <= peak_next;
        last_reg  <= last_next;
    end

    assign result_valid = valid_reg;
    assign peak_level   = peak_reg;
    assign last_time    = last_reg;

    // result strobe only after a lookup walk, and with the block free again
    `THLP_ASSERT(a_result_idle, result_valid |-> !busy, "result shown while busy")
    `THLP_ASSERT(a_result_after_walk, result_valid |-> $past(busy), "result without a walk")
    // after a record the block stays free and gives no result
    `THLP_ASSERT(a_record_single, (start && !busy && !command) |=> (!busy && !result_valid),
        "record did not complete in one cycle")
    // the scan start moves only when a lookup finishes
    `THLP_ASSERT(a_start_moves, !$stable(scan_start_reg) |-> result_valid,
        "scan start moved outside a lookup end")

endmodule

[tb/sv/thlp_tb_pkg.sv]
`timescale 1ns / 1ps
// request codes and the peak history checker for the timed level history peak testbench
package thlp_tb_pkg;

    import thlp_pkg::*;

    localparam int RING_DEPTH = 64;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    class peak_history_checker;

        typedef struct {
            word_t peak;
            word_t last;
        } peak_answer_t;

        word_t stamp_ring[RING_DEPTH];
        word_t level_ring[RING_DEPTH];
        int unsigned write_idx;
        int unsigned scan_idx;
        peak_answer_t pending_peaks[$];
        int unsigned failures;

        function new();
            foreach (stamp_ring[i])
            begin
                stamp_ring[i] = '0;
                level_ring[i] = '0;
            end
            write_idx = 0;
            scan_idx = 0;
            failures = 0;
        endfunction

        function int unsigned pending();
            return pending_peaks.size();
        endfunction

        // update the ring copy for an accepted request, queue the lookup answer
        function void note_request(logic cmd, word_t stamp, word_t lvl);
            peak_answer_t answer;
            int unsigned idx;
            word_t diff;
            if (cmd == CMD_RECORD)
            begin
                stamp_ring[write_idx] = stamp;
                level_ring[write_idx] = lvl;
                write_idx = (write_idx + 1) % RING_DEPTH;
                return;
            end
            answer.peak = PEAK_INIT;
            answer.last = '0;
            idx = scan_idx;
            for (int n = 0; n < RING_DEPTH; n++)
            begin
                if (level_ring[idx] > answer.peak)
                    answer.peak = level_ring[idx];
                answer.last = stamp_ring[idx];
                // wrapping difference, read as signed
                diff = stamp_ring[idx] - stamp;
                if (diff > 0)
                begin
                    scan_idx = idx;
                    break;
                end
                idx = (idx + 1) % RING_DEPTH;
            end
            pending_peaks.push_back(answer);
        endfunction

        function void report_mismatch(string field, word_t want, word_t got);
            failures++;
            $display("%0t mismatch on %s: expected %0d (%h) actual %0d (%h)",
                     $time, field, want, want, got, got);
        endfunction

        // compare one strobed result with the oldest queued answer
        function void check_peak(word_t peak, word_t last);
            peak_answer_t want;
            if (pending_peaks.size() == 0)
            begin
                failures++;
                $display("%0t unexpected result: expected none actual peak %0d last %0d",
                         $time, peak, last);
                return;
            end
            want = pending_peaks.pop_front();
            if (peak !== want.peak)
                report_mismatch("peak_level", want.peak, peak);
            if (last !== want.last)
                report_mismatch("last_time", want.last, last);
        endfunction

    endclass

endpackage

[tb/sv/tb_timed_level_history_peak_core.sv]
`timescale 1ns / 1ps
// testbench top: drives records and lookups, checks every peak result against a ring copy
module tb_timed_level_history_peak_core;

    import thlp_pkg::*;
    import thlp_tb_pkg::*;

    localparam int HIST_DEPTH = RING_DEPTH;
    // a lookup may walk the whole ring, a ram read and a compare per entry, then strobe
    localparam int SETTLE_CYCLES = 2 * HIST_DEPTH + 8;
    localparam int RANDOM_REQUESTS = 630;
    // slowest run is about 650 full-circle lookups plus gaps, near 1 ms
    localparam longint RUN_LIMIT_NS = 5_000_000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  command = CMD_RECORD;
    word_t time_stamp = '0;
    word_t level = '0;
    logic  busy;
    logic  result_valid;
    word_t peak_level;
    word_t last_time;

    peak_history_checker peaks;
    // requests left in the current burst before the sender idles
    int unsigned burst_left;
    // running millisecond clock for well-formed record streams
    word_t now_ms;

    timed_level_history_peak_core #(
        .HIST_DEPTH(HIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .time_stamp(time_stamp),
        .level(level),
        .result_valid(result_valid),
        .peak_level(peak_level),
        .last_time(last_time)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop in case a result or a handshake never comes
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: the strobe lasts one cycle and cannot be held off,
    // so every cycle with the strobe high is checked
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            peaks.check_peak(peak_level, last_time);
    end

    // one request: possibly idle between bursts, then hold start until an edge with busy low;
    // start is left high so the next request can follow without a gap
    task automatic send_request(input logic cmd, input word_t stamp, input word_t lvl);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // mostly short bursts, now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        start      <= 1'b1;
        command    <= cmd;
        time_stamp <= stamp;
        level      <= lvl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        peaks.note_request(cmd, stamp, lvl);
    endtask

    // sender holds off until every lookup answer has been seen
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (peaks.pending() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    task automatic run_directed();
        // cleared ring: nothing later than zero, so a full circle over zero entries
        send_request(CMD_LOOKUP, 32'sd0, $urandom);
        // cleared entry at the scan start is later than -1 and stops at once
        send_request(CMD_LOOKUP, -32'sd1, $urandom);
        // level extremes with ordinary stamps
        send_request(CMD_RECORD, 32'sd100, 32'sh7FFF_FFFF);
        send_request(CMD_RECORD, 32'sd200, 32'sh8000_0000);
        send_request(CMD_RECORD, 32'sd300, -32'sd1);
        // stamps on both sides of the signed wrap
        send_request(CMD_RECORD, 32'sh7FFF_FFFF, 32'sd5);
        send_request(CMD_RECORD, 32'sh8000_0000, -32'sd7);
        // stop on the first visited entry, then on the second
        send_request(CMD_LOOKUP, 32'sd50, $urandom);
        send_request(CMD_LOOKUP, 32'sd150, $urandom);
        // visited levels all negative, peak stays at -1
        send_request(CMD_LOOKUP, 32'sd250, $urandom);
        // largest stamp against the smallest one: wrapping difference is +1
        send_request(CMD_LOOKUP, 32'sh7FFF_FFFF, $urandom);
        // nothing later than the most negative query: full circle, start kept
        send_request(CMD_LOOKUP, 32'sh8000_0000, $urandom);
        send_request(CMD_RECORD, 32'sd0, 32'sd0);
        send_request(CMD_RECORD, -32'sd5, 32'sh7FFF_FFFF);
        send_request(CMD_RECORD, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_request(CMD_RECORD, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_request(CMD_LOOKUP, -32'sd1, 32'shFFFF_FFFF);
        send_request(CMD_LOOKUP, 32'sh5555_5555, 32'sd0);
        send_request(CMD_LOOKUP, 32'shAAAA_AAAA, $urandom);
        send_request(CMD_LOOKUP, 32'sd0, $urandom);
    endtask

    // mostly rising stamps with lookups a little behind the newest sample,
    // plus random stamps and queries as noise
    task automatic run_random(input int unsigned count);
        word_t lvl;
        word_t query;
        for (int unsigned i = 0; i < count; i++)
        begin
            // restart the stream now and then, sometimes close to the signed wrap
            if (i % 160 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: now_ms = 32'sh7FFF_FF00 - word_t'($urandom_range(0, 1500));
                    1: now_ms = $urandom;
                    default: now_ms = now_ms + word_t'($urandom_range(0, 1000));
                endcase
            end
            if (i == count / 2 || $urandom_range(0, 99) == 0)
                wait_for_results();
            case ($urandom_range(0, 3))
                0: lvl = $urandom;
                1: lvl = word_t'($urandom_range(0, 5000));
                2: lvl = -word_t'($urandom_range(1, 5000));
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: lvl = 32'sh7FFF_FFFF;
                        1: lvl = 32'sh8000_0000;
                        2: lvl = -32'sd1;
                        default: lvl = 32'sd0;
                    endcase
                end
            endcase
            case ($urandom_range(0, 19))
                0: send_request(CMD_RECORD, $urandom, lvl);
                1: send_request(CMD_LOOKUP, $urandom, $urandom);
                2, 3, 4:
                begin
                    query = now_ms - word_t'($urandom_range(0, 400));
                    send_request(CMD_LOOKUP, query, $urandom);
                end
                5:
                begin
                    // at or past the newest sample, usually a full circle
                    query = now_ms + word_t'($urandom_range(0, 50));
                    send_request(CMD_LOOKUP, query, $urandom);
                end
                default:
                begin
                    now_ms = now_ms + word_t'($urandom_range(1, 20));
                    send_request(CMD_RECORD, now_ms, lvl);
                end
            endcase
        end
    endtask

    initial
    begin
        peaks = new();
        burst_left = 0;
        now_ms = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_results();
        run_random(RANDOM_REQUESTS);
        wait_for_results();
        // catch any stray strobe after the last answer
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (peaks.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/thlp_pkg.sv
hw/rtl/thlp_ram.sv
hw/rtl/thlp_scan.sv
hw/rtl/timed_level_history_peak_core.sv
tb/sv/thlp_tb_pkg.sv
tb/sv/tb_timed_level_history_peak_core.sv
